[rtl/dks_pkg.sv]
`default_nettype none
package dks_pkg;

	localparam int MAX_TOKEN = 64;
	localparam int IDX_W     = $clog2(MAX_TOKEN);
	localparam int LEN_W     = $clog2(MAX_TOKEN + 1);
	localparam int ADDR_W    = IDX_W + 1;
	localparam int RAM_DEPTH = 1 << ADDR_W;

	localparam int BYTE_W    = 8;
	localparam int MAP_W     = 1 << BYTE_W;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int MINLEN_W  = 7;

	localparam logic [CFG_W-1:0]    MAP_LOW_RST     = 64'd126585571116032;
	localparam logic [CFG_W-1:0]    MAP_MID_LOW_RST = 64'd2882303764335689729;
	localparam logic [CFG_W-1:0]    MAP_MID_HI_RST  = 64'd0;
	localparam logic [CFG_W-1:0]    MAP_HIGH_RST    = 64'd0;
	localparam logic [MINLEN_W-1:0] MIN_LEN_RST     = 7'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAP_LOW     = 3'd0,
		CFG_MAP_MID_LOW = 3'd1,
		CFG_MAP_MID_HI  = 3'd2,
		CFG_MAP_HIGH    = 3'd3,
		CFG_MIN_LEN     = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		BK_IDLE,
		BK_SHOW
	} back_state_t;

	// one closed token waiting to be drained
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		logic             ovf;
	} dks_desc_t;

endpackage
`default_nettype wire

[rtl/dks_ifs.sv]
`default_nettype none
interface dks_in_if;
	import dks_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              keyword_end;

	modport source (output valid, output in_byte, output keyword_end, input ready);
	modport sink (input valid, input in_byte, input keyword_end, output ready);
endinterface

interface dks_out_if;
	import dks_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] token_byte;
	logic              token_last;
	logic              truncated;

	modport source (output valid, output token_byte, output token_last, output truncated,
		input ready);
	modport sink (input valid, input token_byte, input token_last, input truncated,
		output ready);
endinterface
`default_nettype wire

[rtl/dks_ram.sv]
`default_nettype none
module dks_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/dks_front.sv]
`default_nettype none
module dks_front import dks_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	dks_in_if.sink                   in_ch,
	input  wire logic [MAP_W-1:0]    delim_map,
	input  wire logic [MINLEN_W-1:0] min_length,
	input  wire logic                q_full,
	output logic                     push,
	output dks_desc_t                push_desc,
	output logic                     ram_we,
	output logic [ADDR_W-1:0]        ram_waddr,
	output logic [BYTE_W-1:0]        ram_wdata
);

	logic [LEN_W-1:0]    len_q;
	logic                ovf_q;
	logic                seen_q;
	logic                bank_q;

	logic                accept;
	logic                is_delim;
	logic                buf_full;
	logic [LEN_W-1:0]    len_inc;
	logic                ovf_nx;
	logic                closing;
	logic                allowed;
	logic [LEN_W-1:0]    close_len;
	logic                close_ovf;
	logic [MINLEN_W-1:0] need;

	// both banks busy means the queue is full
	assign in_ch.ready = !q_full;

	always_comb begin
		accept    = in_ch.valid && in_ch.ready;
		is_delim  = delim_map[in_ch.in_byte];
		need      = (min_length == '0) ? MINLEN_W'(1) : min_length;
		buf_full  = (len_q == LEN_W'(MAX_TOKEN));
		len_inc   = buf_full ? len_q : len_q + LEN_W'(1);
		ovf_nx    = ovf_q || buf_full;

		if (is_delim) begin
			closing   = 1'b1;
			allowed   = 1'b1;
			close_len = len_q;
			close_ovf = ovf_q;
		end else begin
			closing   = in_ch.keyword_end;
			allowed   = seen_q;
			close_len = len_inc;
			close_ovf = ovf_nx;
		end

		push = accept && closing && allowed && (close_len != '0)
			&& (MINLEN_W'(close_len) >= need);
		push_desc.bank = bank_q;
		push_desc.len  = close_len;
		push_desc.ovf  = close_ovf;

		ram_we    = accept && !is_delim && !buf_full;
		ram_waddr = {bank_q, len_q[IDX_W-1:0]};
		ram_wdata = in_ch.in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			seen_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (accept) begin
			if (is_delim || in_ch.keyword_end) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				len_q <= len_inc;
				ovf_q <= ovf_nx;
			end
			seen_q <= in_ch.keyword_end ? 1'b0 : (seen_q || is_delim);
			if (push) begin
				bank_q <= !bank_q;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/dks_queue.sv]
`default_nettype none
module dks_queue import dks_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire dks_desc_t push_desc,
	output logic           full,
	input  wire logic      pop,
	output logic           q_valid,
	output dks_desc_t      q_desc
);

	dks_desc_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("token queue overrun");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !q_valid))
		else $error("token queue underrun");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("token queue count out of range");

endmodule
`default_nettype wire

[rtl/dks_back.sv]
`default_nettype none
module dks_back import dks_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_valid,
	input  wire dks_desc_t         q_desc,
	output logic                   pop,
	output logic                   ram_re,
	output logic [ADDR_W-1:0]      ram_raddr,
	input  wire logic [BYTE_W-1:0] ram_rdata,
	dks_out_if.source              out_ch
);

	back_state_t      state_q;
	back_state_t      state_nx;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] idx_nx;
	logic             last;

	assign last = (LEN_W'(idx_q) + LEN_W'(1)) == q_desc.len;

	assign out_ch.valid      = (state_q == BK_SHOW);
	assign out_ch.token_byte = ram_rdata;
	assign out_ch.token_last = last;
	assign out_ch.truncated  = q_desc.ovf;

	always_comb begin
		state_nx  = state_q;
		idx_nx    = idx_q;
		ram_re    = 1'b0;
		ram_raddr = {q_desc.bank, idx_q};
		pop       = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					ram_re    = 1'b1;
					ram_raddr = {q_desc.bank, {IDX_W{1'b0}}};
					idx_nx    = '0;
					state_nx  = BK_SHOW;
				end
			end
			BK_SHOW: begin
				if (out_ch.ready) begin
					if (last) begin
						pop      = 1'b1;
						state_nx = BK_IDLE;
					end else begin
						ram_re    = 1'b1;
						idx_nx    = idx_q + IDX_W'(1);
						ram_raddr = {q_desc.bank, idx_nx};
					end
				end
			end
			default: state_nx = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			idx_q   <= idx_nx;
		end
	end

	a_show_has_desc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SHOW |-> q_valid)
		else $error("drain active without a queued token");

endmodule
`default_nettype wire

[rtl/delimiter_keyword_splitter_unit.sv]
`default_nettype none
// Channel   Dir  Payload                               Transfer
// in_ch     in   in_byte[7:0], keyword_end             valid && ready
// out_ch    out  token_byte[7:0], token_last, truncated valid && ready
// cfg       in   cfg_index[2:0], cfg_wdata[63:0]        cfg_we (no back-pressure)
//
// Input side takes one byte per cycle whenever a token bank is free; it
// stalls only while both banks hold closed tokens not yet drained.
// Output side sends one byte of a token per cycle while out_ch is ready, and
// passes through its idle state between tokens to issue the read of the next
// token's first byte on the single read port of the token RAM.
// arst_n clears all control state and restores the configuration defaults;
// RAM contents are not cleared (only written bytes are ever read).
module delimiter_keyword_splitter_unit import dks_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	dks_in_if.sink                    in_ch,
	dks_out_if.source                 out_ch
);

	// configuration registers
	logic [CFG_W-1:0]    map_low_q;
	logic [CFG_W-1:0]    map_mid_low_q;
	logic [CFG_W-1:0]    map_mid_hi_q;
	logic [CFG_W-1:0]    map_high_q;
	logic [MINLEN_W-1:0] min_len_q;

	// front -> queue
	logic                push;
	dks_desc_t           push_desc;
	logic                q_full;

	// queue -> back
	logic                q_valid;
	dks_desc_t           q_desc;
	logic                pop;

	// token RAM: two banks of MAX_TOKEN bytes, bank bit is the address MSB
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [BYTE_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [BYTE_W-1:0]   ram_rdata;

	// indexes beyond the register list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_low_q     <= MAP_LOW_RST;
			map_mid_low_q <= MAP_MID_LOW_RST;
			map_mid_hi_q  <= MAP_MID_HI_RST;
			map_high_q    <= MAP_HIGH_RST;
			min_len_q     <= MIN_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_LOW:     map_low_q     <= cfg_wdata;
				CFG_MAP_MID_LOW: map_mid_low_q <= cfg_wdata;
				CFG_MAP_MID_HI:  map_mid_hi_q  <= cfg_wdata;
				CFG_MAP_HIGH:    map_high_q    <= cfg_wdata;
				CFG_MIN_LEN:     min_len_q     <= cfg_wdata[MINLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: classifies each byte, stores token bytes, decides emission at close
	dks_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.delim_map  ({map_high_q, map_mid_hi_q, map_mid_low_q, map_low_q}),
		.min_length (min_len_q),
		.q_full     (q_full),
		.push       (push),
		.push_desc  (push_desc),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	// Two-entry queue of closed tokens, one per bank
	dks_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_desc    (q_desc)
	);

	dks_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Back: drains a queued token byte by byte; the RAM read register
	// holds the byte on offer while out_ch stalls
	dks_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_desc    (q_desc),
		.pop       (pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire
